// File: sv/mtrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrg_pkg
// Types and constants shared by the range generator modules.
// ----------------------------------------------------------------------------
package mtrg_pkg;

    localparam int STATE_WORDS = 624;
    localparam int TAP_OFFSET  = 397;

    localparam logic [31:0] SEED_MULT = 32'd1812433253;
    localparam logic [31:0] TWIST_XOR = 32'h9908B0DF;
    localparam logic [31:0] TEMPER_B  = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C  = 32'hEFC60000;

    localparam logic [1:0] FUNC_RAW    = 2'd0;
    localparam logic [1:0] FUNC_SCALED = 2'd1;
    localparam logic [1:0] FUNC_REJECT = 2'd2;

    localparam logic [1:0] REG_SEED = 2'd0;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        word;
        logic signed [31:0] number;
        logic               range_error;
    } t_out_item;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_div_status;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: sv/mtrg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrg_cell
// One state word of the twister chain; takes its neighbor's word on shift.
// ----------------------------------------------------------------------------
module mtrg_cell (
    input  logic        i_clk,
    input  logic        i_shift,
    input  logic [31:0] i_d,
    output logic [31:0] o_q
);

    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: sv/mtrg_remdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrg_remdiv
// Bit-serial restoring divider giving 2^32 mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module mtrg_remdiv
    import mtrg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_divisor,
    output t_div_status o_status
);

    logic [32:0] r_rem;
    logic [32:0] n_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;

    // dividend is a one followed by 32 zeros, msb first
    assign w_trial = {r_rem[31:0], (r_cnt == 6'd0)};

    always_comb begin
        if (w_trial >= i_divisor) begin
            n_rem = w_trial - i_divisor;
        end else begin
            n_rem = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_status.done = r_done;
    assign o_status.rem  = r_rem[31:0];

endmodule

// File: sv/mersenne_twister_range_generator_top.sv
`timescale 1ns / 1ps
// flow: ST_CHK, then ST_DRAW in raw mode or ST_DRAW, ST_MUL, ST_EVAL in the range modes;
// equal or reversed bounds go straight to ST_FIN; a rejected draw goes back to ST_DRAW,
// and mode 2 first runs ST_DIV (bit-serial remainder unit) when it sees a new interval;
// a stalled output holds the item in ST_FIN; o_stall is high outside ST_IDLE, so a new
// item is taken only after the last leaves ST_FIN; a draw is one shift of the 624-cell chain
// reset and seed writes: fill of all 624 cells then WARMUP_DRAWS warm-up shifts, o_stall high
// ----------------------------------------------------------------------------
// mersenne_twister_range_generator_top
// MT19937 generator with raw, scaled and unbiased integer range modes.
// ----------------------------------------------------------------------------
module mersenne_twister_range_generator_top
    import mtrg_pkg::*;
#(
    parameter int WARMUP_DRAWS = 37
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WarmW = (WARMUP_DRAWS > 0) ? $clog2(WARMUP_DRAWS + 1) : 1;

    localparam logic [3:0] ST_SEED = 4'd0;
    localparam logic [3:0] ST_WARM = 4'd1;
    localparam logic [3:0] ST_IDLE = 4'd2;
    localparam logic [3:0] ST_CHK  = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_DRAW = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_EVAL = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0]       r_state;
    logic [9:0]       r_seed_cnt;
    logic [WarmW-1:0] r_warm_cnt;
    logic [31:0]      r_seed;
    logic [32:0]      r_cached;
    logic [31:0]      r_limit;
    t_in_item         r_in;
    logic [32:0]      r_interval;
    logic [31:0]      r_w;
    logic [63:0]      r_prod;
    t_out_item        r_res;
    t_out_item        r_out;
    logic             r_out_valid;

    logic        w_cfg_wr;
    logic        w_accept;
    logic        w_shift;
    logic [31:0] w_push;
    logic [31:0] w_twist;
    logic [31:0] w_seed_word;
    logic [31:0] w_y;
    logic        w_div_start;
    logic        w_load;
    logic signed [33:0] w_sum;
    t_div_status w_div;

    logic [31:0] w_cell_q [STATE_WORDS];

    assign pready   = 1'b1;
    assign prdata   = r_seed;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == REG_SEED);

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    // twist recurrence from the oldest two cells and the tap cell
    assign w_y     = {w_cell_q[0][31], w_cell_q[1][30:0]};
    assign w_twist = w_cell_q[TAP_OFFSET] ^ (w_y >> 1) ^ (w_y[0] ? TWIST_XOR : 32'h0);

    assign w_seed_word = SEED_MULT * (w_cell_q[STATE_WORDS-1]
                         ^ (w_cell_q[STATE_WORDS-1] >> 30)) + {22'd0, r_seed_cnt};

    always_comb begin
        if (r_state == ST_SEED) begin
            w_push = (r_seed_cnt == 10'd0) ? r_seed : w_seed_word;
        end else begin
            w_push = w_twist;
        end
    end

    assign w_shift = !w_cfg_wr &&
                     (r_state == ST_SEED || r_state == ST_WARM || r_state == ST_DRAW);

    genvar g;
    generate
        for (g = 0; g < STATE_WORDS; g++) begin : g_chain
            if (g == STATE_WORDS - 1) begin : g_end
                mtrg_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_d     (w_push),
                    .o_q     (w_cell_q[g])
                );
            end else begin : g_mid
                mtrg_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_d     (w_cell_q[g+1]),
                    .o_q     (w_cell_q[g])
                );
            end
        end
    endgenerate

    assign w_div_start = (r_state == ST_CHK) && (r_in.func == FUNC_REJECT) &&
                         (r_in.high_bound > r_in.low_bound) && (r_interval != r_cached);

    mtrg_remdiv u_remdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (r_interval),
        .o_status  (w_div)
    );

    assign w_sum  = $signed({2'b00, r_prod[63:32]}) + 34'(r_in.low_bound);
    assign w_load = (r_state == ST_FIN) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SEED;
            r_seed_cnt  <= '0;
            r_warm_cnt  <= '0;
            r_seed      <= '0;
            r_cached    <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_seed     <= pwdata;
                r_state    <= ST_SEED;
                r_seed_cnt <= '0;
            end else begin
                case (r_state)
                    ST_SEED: begin
                        r_seed_cnt <= r_seed_cnt + 10'd1;
                        if (r_seed_cnt == 10'(STATE_WORDS - 1)) begin
                            r_warm_cnt <= '0;
                            r_state    <= (WARMUP_DRAWS > 0) ? ST_WARM : ST_IDLE;
                        end
                    end
                    ST_WARM: begin
                        r_warm_cnt <= r_warm_cnt + WarmW'(1);
                        if (r_warm_cnt == WarmW'(WARMUP_DRAWS - 1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (w_accept) begin
                            r_state <= ST_CHK;
                        end
                    end
                    ST_CHK: begin
                        if (r_in.func == FUNC_SCALED || r_in.func == FUNC_REJECT) begin
                            if (r_in.high_bound <= r_in.low_bound) begin
                                r_state <= ST_FIN;
                            end else if (w_div_start) begin
                                r_state <= ST_DIV;
                            end else begin
                                r_state <= ST_DRAW;
                            end
                        end else begin
                            r_state <= ST_DRAW;
                        end
                    end
                    ST_DIV: begin
                        if (w_div.done) begin
                            r_limit  <= ~w_div.rem;
                            r_cached <= r_interval;
                            r_state  <= ST_DRAW;
                        end
                    end
                    ST_DRAW: begin
                        if (r_in.func == FUNC_SCALED || r_in.func == FUNC_REJECT) begin
                            r_state <= ST_MUL;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                    ST_MUL: begin
                        r_state <= ST_EVAL;
                    end
                    ST_EVAL: begin
                        if (r_in.func == FUNC_REJECT && r_prod[31:0] > r_limit) begin
                            r_state <= ST_DRAW;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                    ST_FIN: begin
                        if (w_load) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in       <= i_item;
            r_interval <= 33'({i_item.high_bound[31], i_item.high_bound}
                         - {i_item.low_bound[31], i_item.low_bound} + 33'd1);
        end
        if (r_state == ST_CHK) begin
            r_res.word <= '0;
            if (r_in.func == FUNC_SCALED || r_in.func == FUNC_REJECT) begin
                if (r_in.high_bound < r_in.low_bound) begin
                    r_res.number      <= 32'sh80000000;
                    r_res.range_error <= 1'b1;
                end else begin
                    r_res.number      <= r_in.low_bound;
                    r_res.range_error <= 1'b0;
                end
            end else begin
                r_res.number      <= '0;
                r_res.range_error <= 1'b0;
            end
        end
        if (r_state == ST_DRAW) begin
            r_w        <= temper(w_twist);
            r_res.word <= temper(w_twist);
        end
        if (r_state == ST_MUL) begin
            if (r_interval[32]) begin
                r_prod <= {r_w, 32'h0};
            end else begin
                r_prod <= r_w * r_interval[31:0];
            end
        end
        if (r_state == ST_EVAL) begin
            if (r_in.func == FUNC_SCALED && w_sum > 34'(r_in.high_bound)) begin
                r_res.number <= r_in.high_bound;
            end else begin
                r_res.number <= w_sum[31:0];
            end
        end
        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_seed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_state == ST_SEED && o_stall))
        else $error("seed write did not restart fill");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.range_error) |-> (o_item.number == 32'sh80000000
                                              && o_item.word == 32'h0))
        else $error("range error result malformed");

    a_no_shift_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_shift)
        else $error("chain shifted while idle");

    a_div_cache: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && w_div.done && !w_cfg_wr) |=> (r_cached == r_interval))
        else $error("interval cache not updated");

endmodule
